FILE: sv/labelled_pair_distance_sums_defines.svh
// assertion macros for the distance-sum block
`ifndef LABELLED_PAIR_DISTANCE_SUMS_DEFINES_SVH
`define LABELLED_PAIR_DISTANCE_SUMS_DEFINES_SVH
`ifndef SYNTHESIS
`define LPDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lpds check failed");
`define LPDS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lpds reset check failed");
`else
`define LPDS_ASSERT(lbl, clk, rst_n, prop)
`define LPDS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: sv/lpds_pkg.sv
package lpds_pkg;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int MAX_DIMS_DEF = 8;
  localparam int COORD_BITS_DEF = 16;
  localparam int LABEL_W = 16;
  localparam int SUM_W = 28;
  localparam int IDX_W = 11;
  localparam int DIMS_W = 4;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUN  = 5'b00010,
    ST_SQRT = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;
endpackage

FILE: sv/lpds_if.sv
interface lpds_in_if #(
  parameter int MAX_DIMS = lpds_pkg::MAX_DIMS_DEF,
  parameter int COORD_BITS = lpds_pkg::COORD_BITS_DEF
);
  logic valid;
  logic ready;
  logic new_set;
  logic [lpds_pkg::LABEL_W-1:0] label;
  logic signed [COORD_BITS-1:0] coord [MAX_DIMS];
  modport source (output valid, new_set, label, coord, input ready);
  modport sink (input valid, new_set, label, coord, output ready);
endinterface

interface lpds_out_if;
  logic valid;
  logic ready;
  logic [lpds_pkg::SUM_W-1:0] within_sum;
  logic [lpds_pkg::SUM_W-1:0] between_sum;
  logic [lpds_pkg::IDX_W-1:0] point_index;
  logic overflow;
  modport source (output valid, within_sum, between_sum, point_index, overflow, input ready);
  modport sink (input valid, within_sum, between_sum, point_index, overflow, output ready);
endinterface

interface lpds_cfg_if;
  logic valid;
  logic ready;
  logic [lpds_pkg::DIMS_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/lpds_lane.sv
// one coordinate lane: squared difference, registered
module lpds_lane #(
  parameter int COORD_BITS = lpds_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         use_lane,
  input  logic signed [COORD_BITS-1:0] cur,
  input  logic signed [COORD_BITS-1:0] stored,
  output logic [2*COORD_BITS+1:0]      sq_r
);
  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0] mag;
  logic [2*COORD_BITS+1:0] sq_nxt;

  assign diff = {cur[COORD_BITS-1], cur} - {stored[COORD_BITS-1], stored};
  assign mag = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
  assign sq_nxt = use_lane ? mag * mag : '0;

  always_ff @(posedge clk) begin
    if (en) sq_r <= sq_nxt;
  end
endmodule

FILE: sv/lpds_sqrt.sv
// digit-by-digit floor sqrt, one result bit per cycle
module lpds_sqrt #(
  parameter int IN_W = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [IN_W-1:0]      val,
  output logic                 done,
  output logic [IN_W/2-1:0]    root
);
  localparam int HW = IN_W / 2;
  localparam int CW = $clog2(HW + 1);
  logic [IN_W-1:0] rem_r, rem_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [IN_W:0] trial;

  assign trial = {1'b0, root_r} + {1'b0, bit_r};

  always_comb begin
    rem_nxt = rem_r;
    root_nxt = root_r;
    bit_nxt = bit_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt = val;
      root_nxt = '0;
      bit_nxt = {2'b01, {(IN_W-2){1'b0}}};
      cnt_nxt = CW'(HW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[IN_W-1:0];
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    bit_r <= bit_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1));
  assign root = root_nxt[HW-1:0];
endmodule

FILE: sv/labelled_pair_distance_sums.sv
// channel  dir  beat
// in_      in   new_set, label, coord[MAX_DIMS] per point
// out_     out  within_sum, between_sum, point_index, overflow
// cfg_     in   dims_in_use
// one point is served by one pass per held point: each pass fetches one stored point from the
// coordinate memory, then the serial square root runs IN_W/2 steps
// sync reset clears state, points_held and dims_in_use (to MAX_DIMS); memories are not cleared
// a stalled output holds the block until the result beat is taken
`include "labelled_pair_distance_sums_defines.svh"
module labelled_pair_distance_sums #(
  parameter int MAX_POINTS = lpds_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS = lpds_pkg::MAX_DIMS_DEF,
  parameter int COORD_BITS = lpds_pkg::COORD_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  lpds_in_if.sink   in_ch,
  lpds_out_if.source out_ch,
  lpds_cfg_if.sink  cfg_ch
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int HW = $clog2(MAX_POINTS + 1);
  localparam int SQ_W = 2 * COORD_BITS + 2;
  localparam int ACC_W = SQ_W + 3;
  localparam int IN_W = ACC_W + (ACC_W % 2);
  localparam int RT_W = IN_W / 2;
  localparam int SW = lpds_pkg::SUM_W;

  lpds_pkg::state_t st_r, st_nxt;
  logic [lpds_pkg::DIMS_W-1:0] dims_r;
  logic [HW-1:0] held_r, held_nxt, p_r, p_nxt;
  logic signed [COORD_BITS-1:0] cur_r [MAX_DIMS];
  logic [lpds_pkg::LABEL_W-1:0] lab_r;
  logic [SW-1:0] win_r, win_nxt, btw_r, btw_nxt;
  logic same_r;
  logic [lpds_pkg::IDX_W-1:0] idx_r;
  logic ovf_r;
  logic [1:0] phase_r, phase_nxt;

  logic signed [COORD_BITS-1:0] mem_c [MAX_POINTS][MAX_DIMS];
  logic [lpds_pkg::LABEL_W-1:0] mem_l [MAX_POINTS];
  logic signed [COORD_BITS-1:0] rd_c [MAX_DIMS];
  logic [lpds_pkg::LABEL_W-1:0] rd_l;
  logic [SQ_W-1:0] sq [MAX_DIMS];
  logic [ACC_W-1:0] acc;
  logic [3:0] dims_eff;
  logic accept, wr_en, sq_en, sq_start, sq_done;
  logic [RT_W-1:0] root;
  logic [SW:0] add_in;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == lpds_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign dims_eff = (dims_r == '0) ? 4'd1 :
                    (dims_r > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : dims_r;

  // store write and read
  assign wr_en = (st_r == lpds_pkg::ST_DRAIN) && (held_r < HW'(MAX_POINTS));
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int d = 0; d < MAX_DIMS; d++) mem_c[held_r[AW-1:0]][d] <= cur_r[d];
      mem_l[held_r[AW-1:0]] <= lab_r;
    end
    for (int d = 0; d < MAX_DIMS; d++) rd_c[d] <= mem_c[p_r[AW-1:0]][d];
    rd_l <= mem_l[p_r[AW-1:0]];
  end

  // phase 0 read, 1 lanes, 2 sum + sqrt start, 3 wait for root
  assign sq_en = (st_r == lpds_pkg::ST_RUN) && (phase_r == 2'd1);
  genvar g;
  generate
    for (g = 0; g < MAX_DIMS; g++) begin : g_lane
      lpds_lane #(.COORD_BITS(COORD_BITS)) u_lane (
        .clk(clk), .en(sq_en), .use_lane(4'(g) < dims_eff),
        .cur(cur_r[g]), .stored(rd_c[g]), .sq_r(sq[g])
      );
    end
  endgenerate

  always_comb begin
    acc = '0;
    for (int d = 0; d < MAX_DIMS; d++) acc = acc + ACC_W'(sq[d]);
  end

  assign sq_start = (st_r == lpds_pkg::ST_RUN) && (phase_r == 2'd2);
  lpds_sqrt #(.IN_W(IN_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(IN_W'(acc)),
    .done(sq_done), .root(root)
  );

  always_comb begin
    add_in = same_r ? {1'b0, win_r} : {1'b0, btw_r};
    if (RT_W > SW) begin
      if (|(root >> SW)) add_in = {1'b1, {SW{1'b0}}};
      else add_in = add_in + (SW+1)'(root);
    end else begin
      add_in = add_in + (SW+1)'(root);
    end
  end

  always_comb begin
    st_nxt = st_r;
    p_nxt = p_r;
    phase_nxt = phase_r;
    held_nxt = held_r;
    win_nxt = win_r;
    btw_nxt = btw_r;
    case (st_r)
      lpds_pkg::ST_IDLE: begin
        if (accept) begin
          win_nxt = '0;
          btw_nxt = '0;
          p_nxt = '0;
          phase_nxt = 2'd0;
          if (in_ch.new_set) held_nxt = '0;
          if (in_ch.new_set || held_r == '0) st_nxt = lpds_pkg::ST_DRAIN;
          else st_nxt = lpds_pkg::ST_RUN;
        end
      end
      lpds_pkg::ST_RUN: begin
        if (phase_r != 2'd3) phase_nxt = phase_r + 2'd1;
        else if (sq_done) begin
          if (same_r) win_nxt = add_in[SW] ? lpds_pkg::SUM_MAX : add_in[SW-1:0];
          else btw_nxt = add_in[SW] ? lpds_pkg::SUM_MAX : add_in[SW-1:0];
          phase_nxt = 2'd0;
          p_nxt = p_r + 1'b1;
          if (p_r + 1'b1 == held_r) st_nxt = lpds_pkg::ST_DRAIN;
        end
      end
      lpds_pkg::ST_DRAIN: begin
        if (held_r < HW'(MAX_POINTS)) held_nxt = held_r + 1'b1;
        st_nxt = lpds_pkg::ST_OUT;
      end
      lpds_pkg::ST_OUT: begin
        if (out_ch.ready) st_nxt = lpds_pkg::ST_IDLE;
      end
      default: st_nxt = lpds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lpds_pkg::ST_IDLE;
      held_r <= '0;
      dims_r <= 4'(MAX_DIMS);
      phase_r <= 2'd0;
    end else begin
      st_r <= st_nxt;
      held_r <= held_nxt;
      phase_r <= phase_nxt;
      if (cfg_ch.valid) dims_r <= cfg_ch.data;
    end
    p_r <= p_nxt;
    win_r <= win_nxt;
    btw_r <= btw_nxt;
    if (accept) begin
      for (int d = 0; d < MAX_DIMS; d++) cur_r[d] <= in_ch.coord[d];
      lab_r <= in_ch.label;
    end
    if (sq_start) same_r <= (rd_l == lab_r);
    if (st_r == lpds_pkg::ST_DRAIN) begin
      ovf_r <= !(held_r < HW'(MAX_POINTS));
      idx_r <= (held_r < HW'(MAX_POINTS)) ? lpds_pkg::IDX_W'(held_r)
                                          : lpds_pkg::IDX_W'(MAX_POINTS);
    end
  end

  assign out_ch.valid = (st_r == lpds_pkg::ST_OUT);
  assign out_ch.within_sum = win_r;
  assign out_ch.between_sum = btw_r;
  assign out_ch.point_index = idx_r;
  assign out_ch.overflow = ovf_r;

  `LPDS_ASSERT(a_held_cap, clk, rst_n, held_r <= HW'(MAX_POINTS))
  `LPDS_ASSERT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid)
  `LPDS_ASSERT(a_no_ovf_slot, clk, rst_n, out_ch.valid && !out_ch.overflow |-> idx_r < held_r)
  `LPDS_ASSERT_RST(a_rst_idle, clk, !rst_n |=> st_r == lpds_pkg::ST_IDLE)
endmodule
